// ===== rtl/core/sid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sid_pkg: shared types and constants of the set intersection store
// Transaction payloads, mode codes and the token that walks the cell row.
// ----------------------------------------------------------------------------
package sid_pkg;

    localparam int VALUE_W       = 32;
    localparam int MODE_W        = 2;
    localparam int DEFAULT_DEPTH = 64;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PROBE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic                      matched;
        logic signed [VALUE_W-1:0] member;
        logic                      status;
    } t_result;

    // One operation in flight along the row of cells.
    typedef struct packed {
        logic                      valid;
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic                      hit;        // a valid entry held the value
        logic                      free_seen;  // a free entry was passed
    } t_token;

endpackage : sid_pkg
`default_nettype wire

// ===== rtl/core/sid_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sid_cell: one entry of the membership store
// Holds one value and its valid bit, updates the passing token and hands it on.
// ----------------------------------------------------------------------------
module sid_cell
    import sid_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_token i_tok,
    input  wire logic   i_wr_en,
    output t_token      o_tok
);

    logic                      r_valid;
    logic                      n_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_cand;
    logic                      n_cand;
    t_token                    r_tok;
    t_token                    n_tok;
    logic                      eq;

    assign eq = r_valid && (r_value == i_tok.value);

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        n_cand  = r_cand;
        if (i_tok.valid) begin
            case (i_tok.mode)
                MODE_LOAD: begin
                    n_tok.hit       = i_tok.hit | eq;
                    n_tok.free_seen = i_tok.free_seen | ~r_valid;
                    // The first free entry seen is the lowest free one.
                    n_cand          = ~r_valid & ~i_tok.free_seen;
                end
                MODE_PROBE: begin
                    if (eq && !i_tok.hit) begin
                        n_valid   = 1'b0;
                        n_tok.hit = 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (i_wr_en && r_cand) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_cand      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_cand      <= n_cand;
            r_tok.valid <= n_tok.valid;
        end
        r_tok.mode      <= n_tok.mode;
        r_tok.value     <= n_tok.value;
        r_tok.hit       <= n_tok.hit;
        r_tok.free_seen <= n_tok.free_seen;
        // The candidate entry is free, so it can take the value as the load
        // passes; the valid bit is only set once the whole row has been seen.
        if (i_tok.valid && (i_tok.mode == MODE_LOAD) && n_cand) begin
            r_value <= i_tok.value;
        end
    end

    assign o_tok = r_tok;

endmodule : sid_cell
`default_nettype wire

// ===== rtl/core/set_intersection_dedup_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// set_intersection_dedup_unit: duplicate-free set intersection store
// Loads build a set of distinct values, probes report and remove members.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------
//  item    | in        | i_valid / o_stall    | i_item   (mode, value)
//  result  | out       | o_valid / i_stall    | o_result (matched, member,
//          |           |                      |           status)
//
// Each transaction walks the row of STORE_DEPTH cells, one cell per cycle. The
// result leaves the row into the finish register and then moves into the
// output register once that register is free or its result is taken. The
// next item is accepted only after the previous result has left the finish
// register. Only one item is in the row at a time.
// Reset is synchronous and active low; it empties the store at once, with no
// clearing pass. A stalled result sits in the output register while the next
// item may already travel the row; a finished result waiting behind a stalled
// output holds the input stall high.
//
// ----------------------------------------------------------------------------
module set_intersection_dedup_unit
    import sid_pkg::*;
#(
    parameter int STORE_DEPTH = DEFAULT_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_item   i_item,
    output logic         o_stall,
    output logic         o_valid,
    output t_result      o_result,
    input  wire logic    i_stall
);

    // Token bus between neighbouring cells; entry 0 is fed from the input.
    t_token  tok [STORE_DEPTH+1];
    t_token  last_tok;
    logic    in_accept;
    logic    wr_en;
    logic    r_busy;
    logic    r_fin_v;
    t_result r_fin;
    t_result fin_res;
    logic    move_out;

    assign in_accept = i_valid && !o_stall;
    // The input waits while a transaction is in the row or its result waits.
    assign o_stall   = r_busy | r_fin_v;

    always_comb begin
        tok[0].valid     = in_accept;
        tok[0].mode      = i_item.mode;
        tok[0].value     = i_item.value;
        tok[0].hit       = 1'b0;
        tok[0].free_seen = 1'b0;
    end

    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_cell
        sid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (tok[g]),
            .i_wr_en (wr_en),
            .o_tok   (tok[g+1])
        );
    end

    assign last_tok = tok[STORE_DEPTH];

    // A load that found no copy and passed a free entry writes into the cell
    // that marked itself as the lowest free one.
    assign wr_en = last_tok.valid && (last_tok.mode == MODE_LOAD) &&
                   !last_tok.hit && last_tok.free_seen;

    always_comb begin
        fin_res.matched = last_tok.hit && (last_tok.mode == MODE_PROBE);
        fin_res.member  = fin_res.matched ? last_tok.value : '0;
        // A load dropped because every entry was taken.
        fin_res.status  = (last_tok.mode == MODE_LOAD) && !last_tok.hit &&
                          !last_tok.free_seen;
    end

    assign move_out = r_fin_v && (!o_valid || !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin_v <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_busy <= 1'b1;
            end else if (last_tok.valid) begin
                r_busy <= 1'b0;
            end
            if (last_tok.valid) begin
                r_fin_v <= 1'b1;
            end else if (move_out) begin
                r_fin_v <= 1'b0;
            end
            if (move_out) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
        if (last_tok.valid) begin
            r_fin <= fin_res;
        end
        if (move_out) begin
            o_result <= r_fin;
        end
    end

endmodule : set_intersection_dedup_unit
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the set intersection store
// Loads, probes and clears are streamed into the unit with random gaps and
// random back-pressure. Every accepted transaction is run through a local
// copy of the membership store, and each result is compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    import sid_pkg::*;

    localparam int DEPTH = DEFAULT_DEPTH;

    // The package names only the three modes that do something. The fourth
    // encoding must be accepted and must leave the store untouched.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Random part of the run and the point at which the sender holds back
    // until the unit has returned everything it owes.
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_AT     = 900;

    // Slowest correct stretch without any transaction: one item walks the whole
    // row plus finish and output registers, the sender waits its longest gap
    // and the receiver its longest hold. The limit is that, many times over.
    localparam int IDLE_LIMIT = 20 * (DEPTH + 2 + 10 + 10);

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_item item;
        int    gap;     // idle cycles before the item is offered
        bit    drain;   // hold the item back until no result is owed
    } t_queued_item;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    t_item   i_item  = '0;
    logic    i_stall = 1'b0;
    logic    o_stall;
    logic    o_valid;
    t_result o_result;

    set_intersection_dedup_unit #(
        .STORE_DEPTH(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_result(o_result),
        .i_stall (i_stall)
    );

    // Items waiting to be offered, and results the unit still owes us.
    t_queued_item items_to_send[$];
    t_result      results_due[$];

    // Local copy of the membership store.
    logic signed [VALUE_W-1:0] held_value[DEPTH];
    bit                        held_used[DEPTH];

    int  queued       = 0;
    int  fail_count   = 0;
    int  gap_left     = 0;
    int  stall_left   = 0;
    bit  send_quiet   = 1'b0;
    bit  take_quiet   = 1'b0;
    bit  item_taken   = 1'b0;
    bit  result_taken = 1'b0;
    int  idle_cycles  = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Works out the result of one item and updates the local store. A load of
    // a value already held changes nothing; otherwise it takes the lowest
    // free entry, or is dropped with status set when there is none. A probe
    // hit reports the value and frees its entry so that later copies miss.
    function automatic t_result predict_result(t_item it);
        t_result r;
        int      hit_idx;
        int      free_idx;
        r        = '0;
        hit_idx  = -1;
        free_idx = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (held_used[i] && held_value[i] == it.value && hit_idx < 0)
                hit_idx = i;
            if (!held_used[i] && free_idx < 0)
                free_idx = i;
        end
        case (it.mode)
            MODE_LOAD: begin
                if (hit_idx < 0) begin
                    if (free_idx < 0) begin
                        r.status = 1'b1;
                    end else begin
                        held_value[free_idx] = it.value;
                        held_used[free_idx]  = 1'b1;
                    end
                end
            end
            MODE_PROBE: begin
                if (hit_idx >= 0) begin
                    held_used[hit_idx] = 1'b0;
                    r.matched          = 1'b1;
                    r.member           = it.value;
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < DEPTH; i++)
                    held_used[i] = 1'b0;
            end
            default: begin
                // The spare encoding has no effect and returns all zero.
            end
        endcase
        return r;
    endfunction

    // Queues one item. The sender alternates between stretches with random
    // gaps and stretches with none, so that back-to-back traffic is covered.
    task automatic push_item(input logic [MODE_W-1:0] mode,
                             input logic signed [VALUE_W-1:0] value);
        t_queued_item q;
        if ($urandom_range(0, 39) == 0)
            send_quiet = !send_quiet;
        q.item.mode  = mode;
        q.item.value = value;
        q.gap        = send_quiet ? 0 : $urandom_range(0, 10);
        q.drain      = (queued == DRAIN_AT);
        items_to_send.insert(items_to_send.size(), q);
        queued++;
    endtask

    // ------------------------------------------------------------------------
    // Sender. Inputs change on the falling edge only. An offered transaction
    // is held, payload and all, until the rising edge that accepts it.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_queued_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !item_taken) begin
            // Still waiting for acceptance: leave everything as it is.
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            i_valid  <= 1'b0;
        end else if (items_to_send.size() == 0
                     || (items_to_send[0].drain && results_due.size() != 0)) begin
            i_valid <= 1'b0;
        end else begin
            nxt     = items_to_send.pop_front();
            i_item  <= nxt.item;
            i_valid <= 1'b1;
            // The next item's gap is counted from the cycle after this one is
            // taken; zero keeps valid high across the two transactions.
            gap_left <= (items_to_send.size() != 0) ? items_to_send[0].gap : 0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Each result is held off for a random number of cycles once it
    // is presented. While nothing is presented the stall line wanders, which
    // the unit must ignore.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        int hold;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            hold = stall_left;
            if (result_taken) begin
                if ($urandom_range(0, 39) == 0)
                    take_quiet = !take_quiet;
                hold = take_quiet ? 0 : $urandom_range(0, 10);
            end
            if (o_valid && hold > 0) begin
                i_stall    <= 1'b1;
                stall_left <= hold - 1;
            end else if (o_valid) begin
                i_stall    <= 1'b0;
                stall_left <= 0;
            end else begin
                i_stall    <= (hold > 0) ? 1'($urandom_range(0, 1)) : 1'b0;
                stall_left <= hold;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Both channels are sampled on the rising edge. The result side
    // is checked before the item side so that an item accepted on this edge
    // can never be mistaken for the result presented on it.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            item_taken   <= 1'b0;
            result_taken <= 1'b0;
        end else begin
            item_taken   <= i_valid && !o_stall;
            result_taken <= o_valid && !i_stall;
            if (o_valid && !i_stall) begin
                got = o_result;
                if (results_due.size() == 0) begin
                    $error("unexpected result: matched=%0d member=%0d status=%0d",
                           got.matched, got.member, got.status);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    if (got.matched !== want.matched) begin
                        $error("matched: expected %0d, got %0d", want.matched, got.matched);
                        fail_count++;
                    end
                    if (got.member !== want.member) begin
                        $error("member: expected %0d, got %0d", want.member, got.member);
                        fail_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall)
                results_due.insert(results_due.size(), predict_result(i_item));
        end
    end

    // Watchdog: a run that stops moving on both channels for too long is hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------------
    initial begin
        logic signed [VALUE_W-1:0] pool[$];
        logic signed [VALUE_W-1:0] v;
        int pool_size;
        int loads;
        int probes;
        int round;

        for (int i = 0; i < DEPTH; i++) begin
            held_value[i] = '0;
            held_used[i]  = 1'b0;
        end

        // Directed part: field extremes, every mode, duplicates, repeated
        // probes, reinsertion after a hit, and values that clear and the
        // spare mode must ignore.
        push_item(MODE_PROBE, 32'sd5);          // probe on an empty store
        push_item(MODE_LOAD,  VALUE_MIN);
        push_item(MODE_LOAD,  VALUE_MAX);
        push_item(MODE_LOAD,  32'sd0);
        push_item(MODE_LOAD,  -32'sd1);
        push_item(MODE_LOAD,  VALUE_MAX);        // already held
        push_item(MODE_PROBE, VALUE_MIN);        // hit
        push_item(MODE_PROBE, VALUE_MIN);        // second copy misses
        push_item(MODE_PROBE, -32'sd1);
        push_item(MODE_PROBE, 32'sd1);           // never loaded
        push_item(MODE_SPARE, -32'sd1);
        push_item(MODE_CLEAR, 32'shA5A5_A5A5);
        push_item(MODE_PROBE, VALUE_MAX);        // gone after the clear
        push_item(MODE_PROBE, 32'sd0);
        push_item(MODE_LOAD,  32'sh5555_5555);
        push_item(MODE_SPARE, 32'sh5555_5555);   // must not remove it
        push_item(MODE_PROBE, 32'sh5555_5555);
        push_item(MODE_CLEAR, 32'sd0);
        push_item(MODE_LOAD,  32'shAAAA_AAAA);
        push_item(MODE_PROBE, 32'shAAAA_AAAB);   // neighbour misses
        push_item(MODE_PROBE, 32'shAAAA_AAAA);
        push_item(MODE_LOAD,  32'shAAAA_AAAA);   // reinsert after the hit
        push_item(MODE_PROBE, 32'shAAAA_AAAA);

        // Random part, mostly whole intersection rounds: a pool of values, a
        // load phase drawn from it with repeats, then a probe phase drawn
        // mostly from the same pool. The first round instead overfills
        // an empty store with distinct values, so that the full case is
        // reached early; later ones may leave entries behind and fill up
        // across rounds. Short bursts of noise fall between the rounds.
        round = 0;
        while (queued < RANDOM_ITEMS + 23) begin
            if (round == 0 || $urandom_range(0, 9) < 7) begin
                pool.delete();
                pool_size = (round == 0) ? DEPTH + 8 : $urandom_range(1, 100);
                for (int i = 0; i < pool_size; i++) begin
                    case ($urandom_range(0, 3))
                        0: v = $urandom_range(0, 15);
                        1: v = -$signed(32'($urandom_range(1, 16)));
                        2: v = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
                        default: v = $urandom;
                    endcase
                    pool.insert(pool.size(), v);
                end
                if (round == 0) begin
                    push_item(MODE_CLEAR, $urandom);
                    for (int i = 0; i < DEPTH + 8; i++)
                        push_item(MODE_LOAD, VALUE_MIN + i);
                end else begin
                    loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 90)
                                                        : $urandom_range(0, 30);
                    for (int i = 0; i < loads; i++)
                        push_item(MODE_LOAD, pool[$urandom_range(0, pool_size - 1)]);
                end
                probes = $urandom_range(0, 40);
                for (int i = 0; i < probes; i++) begin
                    if ($urandom_range(0, 4) == 0)
                        push_item(MODE_PROBE, $urandom);
                    else if (round == 0)
                        push_item(MODE_PROBE, VALUE_MIN + $urandom_range(0, DEPTH + 7));
                    else
                        push_item(MODE_PROBE, pool[$urandom_range(0, pool_size - 1)]);
                end
                if ($urandom_range(0, 1) == 0)
                    push_item(MODE_CLEAR, $urandom);
            end else begin
                repeat ($urandom_range(1, 10))
                    push_item(2'($urandom_range(0, 3)), $urandom);
            end
            round++;
        end

        // Hold reset, then release it on a falling edge.
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last item to go in and its result to come out, then
        // allow one more trip through the row for anything spurious.
        while (items_to_send.size() != 0 || i_valid || results_due.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 4) @(posedge i_clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule : testbench
`default_nettype wire

// ===== set_intersection_dedup_unit.f =====
rtl/core/sid_pkg.sv
rtl/core/sid_cell.sv
rtl/core/set_intersection_dedup_unit.sv
tb/testbench.sv
